// ----- sv/pcss_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the per-class sample statistics unit.
// Used by every module of the block but pcss_ram; depends on nothing.
package pcss_pkg;

    localparam int CLASS_COUNT = 255;
    localparam int VALUE_BITS  = 24;
    localparam int CLASS_BITS  = 8;
    localparam int SLOTS       = 1 << CLASS_BITS;
    localparam int CNT_BITS    = 32;
    localparam int SUM_BITS    = 64;
    localparam int SQ_BITS     = 63;
    localparam int PROD_BITS   = 2 * VALUE_BITS;

    localparam int S_TDATA_BITS = ((CLASS_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = CNT_BITS + 2 * VALUE_BITS + SUM_BITS + SQ_BITS + CNT_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic [1:0] req_t;
    localparam req_t REQ_ADD   = 2'd0;
    localparam req_t REQ_QUERY = 2'd1;
    localparam req_t REQ_CLEAR = 2'd2;

    localparam logic signed [VALUE_BITS-1:0] VAL_MAXPOS = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MAXNEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [SUM_BITS-1:0]   SUM_MAX    = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0]   SUM_MIN    = {1'b1, {(SUM_BITS-1){1'b0}}};
    localparam logic [SQ_BITS-1:0]           SQ_MAX     = {SQ_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]          CNT_MAX    = {CNT_BITS{1'b1}};

    // one class entry as held in the statistics memory
    typedef struct packed {
        logic [SQ_BITS-1:0]           sq_sum;
        logic signed [SUM_BITS-1:0]   sum;
        logic signed [VALUE_BITS-1:0] max;
        logic signed [VALUE_BITS-1:0] min;
        logic [CNT_BITS-1:0]          count;
    } rec_t;

    localparam rec_t REC_EMPTY = '{
        sq_sum: '0, sum: '0, max: VAL_MAXNEG, min: VAL_MAXPOS, count: '0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the accepted item, start the entry read
        logic square;    // register the squared magnitude
        logic commit;    // write back the entry of an add and load the result register
    } cmd_t;

endpackage

// ----- sv/pcss_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/pcss_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the statistics unit: sequences accept, read and update of one item
// and owns the result valid flag. Depends on pcss_pkg.
module pcss_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output pcss_pkg::cmd_t cmd
);
    import pcss_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // take no item while reset is held
                s_tready    = aresetn;
                cmd.capture = s_tvalid && aresetn;
                if (s_tvalid && aresetn) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.square = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the result register can take the new item
                if (out_free) begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- sv/pcss_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the statistics unit: class memory, valid bits, squarer, saturating
// update and result register. Depends on pcss_pkg and pcss_ram.
module pcss_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  pcss_pkg::cmd_t                         cmd,
    input  pcss_pkg::req_t                         in_req,
    input  logic [pcss_pkg::CLASS_BITS-1:0]        in_class,
    input  logic signed [pcss_pkg::VALUE_BITS-1:0] in_value,
    output logic                                   out_status,
    output pcss_pkg::rec_t                         out_rec,
    output logic [pcss_pkg::CNT_BITS-1:0]          out_total
);
    import pcss_pkg::*;

    req_t                         req_reg;
    logic [CLASS_BITS-1:0]        class_reg;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic [PROD_BITS-1:0]         sq_reg;
    logic [SLOTS-1:0]             valid_reg, valid_next;
    logic [CNT_BITS-1:0]          total_reg, total_next;
    logic                         out_status_reg;
    rec_t                         out_rec_reg;
    logic [CNT_BITS-1:0]          out_total_reg;

    rec_t                         rd_rec, new_rec, res_rec;
    logic [VALUE_BITS-1:0]        mag;
    logic                         is_add, is_clear, class_ok, hit, res_status, wr_en;
    logic signed [SUM_BITS-1:0]   value_ext, sum_raw;
    logic                         sum_ovf;
    logic [SQ_BITS:0]             sq_raw;
    logic [CNT_BITS-1:0]          res_total;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= in_req;
            class_reg <= in_class;
            value_reg <= in_value;
        end
        if (cmd.square) begin
            sq_reg <= PROD_BITS'(mag) * PROD_BITS'(mag);
        end
    end

    pcss_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (class_reg),
        .wdata (new_rec),
        .re    (cmd.capture),
        .raddr (in_class),
        .rdata (rd_rec)
    );

    // absolute value; the most negative input maps onto its unsigned magnitude
    assign mag = value_reg[VALUE_BITS-1] ? VALUE_BITS'(-value_reg) : value_reg;

    assign is_add   = req_reg == REQ_ADD;
    assign is_clear = req_reg == REQ_CLEAR;
    assign class_ok = {1'b0, class_reg} < (CLASS_BITS + 1)'(CLASS_COUNT);
    assign hit      = valid_reg[class_reg];
    assign wr_en    = cmd.commit && is_add && class_ok;

    assign value_ext = SUM_BITS'(value_reg);
    assign sum_raw   = rd_rec.sum + value_ext;
    assign sum_ovf   = (rd_rec.sum[SUM_BITS-1] == value_ext[SUM_BITS-1])
                    && (sum_raw[SUM_BITS-1] != rd_rec.sum[SUM_BITS-1]);
    assign sq_raw    = {1'b0, rd_rec.sq_sum} + (SQ_BITS + 1)'(sq_reg);

    always_comb begin
        if (!hit) begin
            new_rec.count  = CNT_BITS'(1);
            new_rec.min    = value_reg;
            new_rec.max    = value_reg;
            new_rec.sum    = value_ext;
            new_rec.sq_sum = SQ_BITS'(sq_reg);
        end else begin
            new_rec.count  = (rd_rec.count == CNT_MAX) ? rd_rec.count : rd_rec.count + 1'b1;
            new_rec.min    = (value_reg < rd_rec.min) ? value_reg : rd_rec.min;
            new_rec.max    = (value_reg > rd_rec.max) ? value_reg : rd_rec.max;
            new_rec.sum    = sum_ovf ? (rd_rec.sum[SUM_BITS-1] ? SUM_MIN : SUM_MAX) : sum_raw;
            new_rec.sq_sum = sq_raw[SQ_BITS] ? SQ_MAX : sq_raw[SQ_BITS-1:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        total_next = total_reg;
        res_status = 1'b0;
        res_rec    = REC_EMPTY;
        res_total  = total_reg;
        priority if (is_clear) begin
            valid_next = '0;
            total_next = '0;
            res_total  = '0;
        end else if (!class_ok) begin
            res_status = 1'b1;
        end else if (is_add) begin
            valid_next[class_reg] = 1'b1;
            total_next = (total_reg == CNT_MAX) ? total_reg : total_reg + 1'b1;
            res_rec    = new_rec;
            res_total  = total_next;
        end else begin
            res_rec = hit ? rd_rec : REC_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            total_reg <= '0;
        end else if (cmd.commit) begin
            valid_reg <= valid_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status_reg <= res_status;
            out_rec_reg    <= res_rec;
            out_total_reg  <= res_total;
        end
    end

    assign out_status = out_status_reg;
    assign out_rec    = out_rec_reg;
    assign out_total  = out_total_reg;

endmodule

// ----- sv/per_class_sample_statistics_unit.sv -----
`timescale 1ns / 1ps
// Per-class sample statistics unit: top level joining controller and datapath.
// Depends on pcss_pkg, pcss_ctrl, pcss_dp (and pcss_ram below it).
//
// Each item is an add, a query or a clear for one of 255 sample classes (class 255
// is rejected with status 1, but a clear on it is not). Every item returns exactly
// one result: the class's count, minimum, maximum, sum and sum of squares, plus the
// running total of added samples; an empty class reads as count 0, most positive
// minimum, most negative maximum and zero sums. Items are handled one at a time:
// the accepting edge also starts the registered read of the class memory, ST_READ
// registers the squared magnitude, and ST_UPDATE does the saturating update and
// write-back and loads the result register. A result is valid once ST_UPDATE has
// loaded it, and the next item can be taken once the controller is back in ST_IDLE.
// A new item can be taken while the previous result still waits in the output
// register; if that register is still full, the update waits for m_tready.
// Clear takes effect at once through per-class valid bits, with no memory sweep.
module per_class_sample_statistics_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // class_id [7:0], sample_value [31:8]
    input  logic [pcss_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // req_type [1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sample_count [31:0], min_value [55:32], max_value [79:56], value_sum [143:80],
    // square_sum [206:144], total_samples [238:207], zero fill above
    output logic [pcss_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // status [0]
    output logic                               m_tuser
);
    import pcss_pkg::*;

    cmd_t                  cmd;
    rec_t                  out_rec;
    logic [CNT_BITS-1:0]   out_total;
    logic                  out_status;

    pcss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pcss_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_req     (s_tuser),
        .in_class   (s_tdata[CLASS_BITS-1:0]),
        .in_value   (s_tdata[CLASS_BITS +: VALUE_BITS]),
        .out_status (out_status),
        .out_rec    (out_rec),
        .out_total  (out_total)
    );

    assign m_tdata = M_TDATA_BITS'({out_total, out_rec.sq_sum, out_rec.sum,
                                    out_rec.max, out_rec.min, out_rec.count});
    assign m_tuser = out_status;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for per_class_sample_statistics_unit: a directed table, then random
// add/query/clear traffic with random stalls on both streams, checked against a predictor.
// Depends on pcss_pkg and the RTL of the unit.
module tb_top;
    import pcss_pkg::*;

    localparam req_t REQ_SPARE   = 2'd3;   // unused code, behaves as a query
    localparam int   N_DIRECTED  = 24;
    localparam int   N_RANDOM    = 400;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   HOLD_CYCLES = 80;
    localparam logic [63:0] SQ_LIMIT64 = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic                         status;
        logic [CNT_BITS-1:0]          count;
        logic signed [VALUE_BITS-1:0] lo_val;
        logic signed [VALUE_BITS-1:0] hi_val;
        logic signed [SUM_BITS-1:0]   sum;
        logic [SQ_BITS-1:0]           sq;
        logic [CNT_BITS-1:0]          total;
    } stats_t;

    typedef struct packed {
        req_t                         req;
        logic [CLASS_BITS-1:0]        cls;
        logic signed [VALUE_BITS-1:0] val;
        logic                         pinned;
        stats_t                       want;
    } row_t;

    localparam stats_t NO_PIN    = '0;
    localparam stats_t EMPTY_OK  = '{1'b0, 32'd0, VAL_MAXPOS, VAL_MAXNEG, 64'sd0, 63'd0, 32'd0};
    localparam stats_t EMPTY_BAD = '{1'b1, 32'd0, VAL_MAXPOS, VAL_MAXNEG, 64'sd0, 63'd0, 32'd0};
    localparam stats_t FIRST_NEG = '{1'b0, 32'd1, VAL_MAXNEG, VAL_MAXNEG, -64'sd8388608,
                                     63'h0000_4000_0000_0000, 32'd1};

    localparam row_t directed_rows [0:N_DIRECTED-1] = '{
        '{REQ_QUERY, 8'd0,   24'sd0,      1'b1, EMPTY_OK},
        '{REQ_QUERY, 8'd255, 24'sd0,      1'b1, EMPTY_BAD},
        '{REQ_ADD,   8'd255, 24'sd5,      1'b1, EMPTY_BAD},
        '{REQ_SPARE, 8'd255, 24'sd0,      1'b1, EMPTY_BAD},
        '{REQ_ADD,   8'd0,   VAL_MAXNEG,  1'b1, FIRST_NEG},
        '{REQ_ADD,   8'd0,   VAL_MAXPOS,  1'b0, NO_PIN},
        '{REQ_ADD,   8'd0,   24'sd0,      1'b0, NO_PIN},
        '{REQ_ADD,   8'd254, -24'sd1,     1'b0, NO_PIN},
        '{REQ_ADD,   8'd254, 24'sd1,      1'b0, NO_PIN},
        '{REQ_QUERY, 8'd254, 24'sd0,      1'b0, NO_PIN},
        '{REQ_SPARE, 8'd254, 24'sd0,      1'b0, NO_PIN},
        '{REQ_ADD,   8'd1,   24'h5A5A5A,  1'b0, NO_PIN},
        '{REQ_ADD,   8'd1,   24'hA5A5A5,  1'b0, NO_PIN},
        '{REQ_QUERY, 8'd0,   24'sd0,      1'b0, NO_PIN},
        '{REQ_CLEAR, 8'd77,  24'h123456,  1'b1, EMPTY_OK},
        '{REQ_QUERY, 8'd0,   24'sd0,      1'b1, EMPTY_OK},
        '{REQ_QUERY, 8'd254, 24'sd0,      1'b1, EMPTY_OK},
        '{REQ_ADD,   8'd255, VAL_MAXNEG,  1'b1, EMPTY_BAD},
        '{REQ_ADD,   8'd254, VAL_MAXPOS,  1'b0, NO_PIN},
        '{REQ_ADD,   8'd254, VAL_MAXPOS,  1'b0, NO_PIN},
        '{REQ_QUERY, 8'd1,   24'sd0,      1'b0, NO_PIN},
        '{REQ_CLEAR, 8'd255, 24'hFFFFFF,  1'b1, EMPTY_OK},
        '{REQ_ADD,   8'd128, 24'sd1,      1'b0, NO_PIN},
        '{REQ_QUERY, 8'd128, 24'sd0,      1'b0, NO_PIN}
    };

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata  = '0;
    logic [1:0]                s_tuser  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      m_tuser;

    // predictor copy of the class memory
    logic                         cls_valid [SLOTS];
    logic [CNT_BITS-1:0]          cls_count [SLOTS];
    logic signed [VALUE_BITS-1:0] cls_lo    [SLOTS];
    logic signed [VALUE_BITS-1:0] cls_hi    [SLOTS];
    logic signed [SUM_BITS-1:0]   cls_sum   [SLOTS];
    logic [63:0]                  cls_sq    [SLOTS];
    logic [CNT_BITS-1:0]          added_total;

    stats_t pending_stats [$];
    int     mismatches   = 0;
    int     cycle_count  = 0;
    bit     calm         = 1'b0;   // no idling on either side
    bit     hold_request = 1'b0;

    per_class_sample_statistics_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Fold one request into the predicted class memory and return the expected result.
    function automatic stats_t fold_request(req_t r, logic [CLASS_BITS-1:0] c,
                                            logic signed [VALUE_BITS-1:0] v);
        stats_t                   res;
        logic [VALUE_BITS-1:0]    mag;
        logic [63:0]              sq;
        logic signed [SUM_BITS:0] wide;
        res = EMPTY_OK;
        if (r == REQ_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) cls_valid[i] = 1'b0;
            added_total = '0;
            return res;
        end
        if (int'(c) >= CLASS_COUNT) begin
            res.status = 1'b1;
            res.total  = added_total;
            return res;
        end
        if (r == REQ_ADD) begin
            mag = v[VALUE_BITS-1] ? VALUE_BITS'(-v) : VALUE_BITS'(v);
            sq  = 64'(mag) * 64'(mag);
            if (!cls_valid[c]) begin
                cls_valid[c] = 1'b1;
                cls_count[c] = 1;
                cls_lo[c]    = v;
                cls_hi[c]    = v;
                cls_sum[c]   = SUM_BITS'(v);
                cls_sq[c]    = sq;
            end else begin
                if (cls_count[c] != CNT_MAX) cls_count[c] = cls_count[c] + 1;
                if (v < cls_lo[c]) cls_lo[c] = v;
                if (v > cls_hi[c]) cls_hi[c] = v;
                wide = $signed({cls_sum[c][SUM_BITS-1], cls_sum[c]}) + (SUM_BITS + 1)'(v);
                if (wide[SUM_BITS] != wide[SUM_BITS-1])
                    cls_sum[c] = wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
                else
                    cls_sum[c] = wide[SUM_BITS-1:0];
                if (cls_sq[c] > SQ_LIMIT64 - sq)
                    cls_sq[c] = SQ_LIMIT64;
                else
                    cls_sq[c] = cls_sq[c] + sq;
            end
            if (added_total != CNT_MAX) added_total = added_total + 1;
        end
        if (cls_valid[c]) begin
            res.count  = cls_count[c];
            res.lo_val = cls_lo[c];
            res.hi_val = cls_hi[c];
            res.sum    = cls_sum[c];
            res.sq     = cls_sq[c][SQ_BITS-1:0];
        end
        res.total = added_total;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
        mismatches++;
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want) report_mismatch(field, got, want);
    endtask

    // Offer one item, idling first at random; queue the expected result once it is taken.
    task automatic send_request(req_t r, logic [CLASS_BITS-1:0] c,
                                logic signed [VALUE_BITS-1:0] v,
                                logic pinned, stats_t want);
        stats_t predicted;
        while (!calm && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, c};
        s_tuser  <= r;
        do @(posedge aclk); while (!s_tready);
        predicted = fold_request(r, c, v);
        pending_stats.push_back(pinned ? want : predicted);
        @(negedge aclk);
    endtask

    function automatic req_t pick_request();
        int p;
        p = $urandom_range(0, 99);
        if (p < 58) return REQ_ADD;
        if (p < 88) return REQ_QUERY;
        if (p < 96) return REQ_SPARE;
        if (p < 98) return REQ_CLEAR;
        return REQ_ADD;
    endfunction

    function automatic logic [CLASS_BITS-1:0] pick_class();
        int p;
        p = $urandom_range(0, 99);
        if (p < 6)  return 8'd255;
        if (p < 30) return CLASS_BITS'($urandom_range(0, CLASS_COUNT - 1));
        if (p < 35) return 8'd254;
        return CLASS_BITS'($urandom_range(0, 7));   // few classes, so they build up
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8)  return VAL_MAXPOS;
        if (p < 16) return VAL_MAXNEG;
        if (p < 24) return VALUE_BITS'($urandom_range(0, 15)) - 24'sd8;
        return VALUE_BITS'($urandom());
    endfunction

    // result side: random stalls plus one long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    always @(posedge aclk) begin
        stats_t seen;
        stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.status = m_tuser;
            seen.count  = m_tdata[31:0];
            seen.lo_val = m_tdata[55:32];
            seen.hi_val = m_tdata[79:56];
            seen.sum    = m_tdata[143:80];
            seen.sq     = m_tdata[206:144];
            seen.total  = m_tdata[238:207];
            if (pending_stats.size() == 0) begin
                report_mismatch("unexpected item", 64'(seen.count), 64'd0);
            end else begin
                want = pending_stats.pop_front();
                check_field("status", 64'(seen.status), 64'(want.status));
                check_field("sample_count", 64'(seen.count), 64'(want.count));
                check_field("min_value", 64'(seen.lo_val), 64'(want.lo_val));
                check_field("max_value", 64'(seen.hi_val), 64'(want.hi_val));
                check_field("value_sum", seen.sum, want.sum);
                check_field("square_sum", 64'(seen.sq), 64'(want.sq));
                check_field("total_samples", 64'(seen.total), 64'(want.total));
            end
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            cls_valid[i] = 1'b0;
            cls_count[i] = '0;
            cls_lo[i]    = '0;
            cls_hi[i]    = '0;
            cls_sum[i]   = '0;
            cls_sq[i]    = '0;
        end
        added_total = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_rows[i].req, directed_rows[i].cls, directed_rows[i].val,
                         directed_rows[i].pinned, directed_rows[i].want);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 120) hold_request = 1'b1;
            calm = (i >= 250 && i < 320);
            send_request(pick_request(), pick_class(), pick_value(), 1'b0, NO_PIN);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/pcss_pkg.sv
sv/pcss_ram.sv
sv/pcss_ctrl.sv
sv/pcss_dp.sv
sv/per_class_sample_statistics_unit.sv
sim/tb_top.sv
